/* hdl/ipv4rx_pkg.sv */
package ipv4rx_pkg;

   localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;

   localparam logic       KIND_REPORT  = 1'b0;
   localparam logic       KIND_PAYLOAD = 1'b1;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd1;
   localparam logic [2:0] STATUS_SHORT    = 3'd2;
   localparam logic [2:0] STATUS_ADDRESS  = 3'd3;
   localparam logic [2:0] STATUS_LENGTH   = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [31:0] src_addr;
      logic [31:0] dest_addr;
      logic [15:0] packet_id;
      logic        dont_fragment;
      logic        more_fragments;
      logic [12:0] frag_offset;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last;
   } result_type;

endpackage

/* hdl/ipv4rx_core.sv */
module ipv4rx_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  first,
   input  logic [31:0]           local_ip_addr,
   output ipv4rx_pkg::result_type res,
   output logic                  res_valid
);
   import ipv4rx_pkg::*;

   logic [15:0] byte_index_ff, byte_index_in;
   logic [5:0]  header_bytes_ff, header_bytes_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] flags_ff, flags_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic        dropping_ff, dropping_in;

   logic [15:0] idx;
   logic [16:0] wide_sum;
   logic [15:0] plen;
   logic [2:0]  status;

   always_comb begin
      byte_index_in   = byte_index_ff;
      header_bytes_in = header_bytes_ff;
      sum_in          = sum_ff;
      hold_in         = hold_ff;
      total_length_in = total_length_ff;
      ident_in        = ident_ff;
      flags_in        = flags_ff;
      src_in          = src_ff;
      dst_in          = dst_ff;
      dropping_in     = dropping_ff;
      idx             = byte_index_ff;
      wide_sum        = '0;
      plen            = '0;
      status          = STATUS_OK;
      res             = '0;
      res_valid       = 1'b0;

      if (first) begin
         byte_index_in   = '0;
         sum_in          = '0;
         hold_in         = '0;
         total_length_in = '0;
         ident_in        = '0;
         flags_in        = '0;
         src_in          = '0;
         dst_in          = '0;
         dropping_in     = 1'b0;
         header_bytes_in = {data_byte[3:0], 2'b00};
      end

      if (first && (header_bytes_in < MIN_HEADER_BYTES)) begin
         // IHL below 5: report right away, drop the rest
         dropping_in = 1'b1;
         res.kind    = KIND_REPORT;
         res.status  = STATUS_SHORT;
         res.last    = 1'b1;
         res_valid   = 1'b1;
      end else if (!dropping_in) begin
         idx           = byte_index_in;
         byte_index_in = idx + 16'd1;

         if (idx < {10'b0, header_bytes_in}) begin
            case (idx) inside
               16'd2, 16'd3:   total_length_in = {total_length_in[7:0], data_byte};
               16'd4, 16'd5:   ident_in        = {ident_in[7:0], data_byte};
               16'd6, 16'd7:   flags_in        = {flags_in[7:0], data_byte};
               [16'd12:16'd15]: src_in         = {src_in[23:0], data_byte};
               [16'd16:16'd19]: dst_in         = {dst_in[23:0], data_byte};
               default: ;
            endcase

            if (!idx[0]) begin
               hold_in = data_byte;
            end else begin
               // ones' complement add, end-around carry
               wide_sum = {1'b0, sum_in} + {1'b0, hold_in, data_byte};
               sum_in   = wide_sum[15:0] + {15'b0, wide_sum[16]};
            end

            if (idx == ({10'b0, header_bytes_in} - 16'd1)) begin
               if (sum_in != 16'hFFFF) begin
                  status = STATUS_CHECKSUM;
               end else if (dst_in != local_ip_addr) begin
                  status = STATUS_ADDRESS;
               end else if (total_length_in < {10'b0, header_bytes_in}) begin
                  status = STATUS_LENGTH;
               end else begin
                  status = STATUS_OK;
                  plen   = total_length_in - {10'b0, header_bytes_in};
               end
               res.kind           = KIND_REPORT;
               res.status         = status;
               res.src_addr       = src_in;
               res.dest_addr      = dst_in;
               res.packet_id      = ident_in;
               res.dont_fragment  = flags_in[14];
               res.more_fragments = flags_in[13];
               res.frag_offset    = flags_in[12:0];
               res.payload_length = plen;
               res.last           = (status != STATUS_OK) || (plen == 16'd0);
               res_valid          = 1'b1;
               if (res.last) begin
                  dropping_in = 1'b1;
               end
            end
         end else begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = data_byte;
            res.last         = ({1'b0, idx} + 17'd1) >= {1'b0, total_length_in};
            res_valid        = 1'b1;
            if (res.last) begin
               dropping_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= '0;
         header_bytes_ff <= '0;
         sum_ff          <= '0;
         hold_ff         <= '0;
         total_length_ff <= '0;
         ident_ff        <= '0;
         flags_ff        <= '0;
         src_ff          <= '0;
         dst_ff          <= '0;
         dropping_ff     <= 1'b1;
      end else if (step) begin
         byte_index_ff   <= byte_index_in;
         header_bytes_ff <= header_bytes_in;
         sum_ff          <= sum_in;
         hold_ff         <= hold_in;
         total_length_ff <= total_length_in;
         ident_ff        <= ident_in;
         flags_ff        <= flags_in;
         src_ff          <= src_in;
         dst_ff          <= dst_in;
         dropping_ff     <= dropping_in;
      end
   end

`ifndef SYNTH
   a_error_ends_packet: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_REPORT) && (res.status != STATUS_OK) |-> res.last)
      else $error("error report without last");

   a_payload_status_ok: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_PAYLOAD) |-> (res.status == STATUS_OK))
      else $error("payload word with nonzero status");

   a_last_drops: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.last |=> dropping_ff)
      else $error("packet still open after last word");

   a_open_header_len: assert property (@(posedge clock) disable iff (reset)
      !dropping_ff |-> (header_bytes_ff >= MIN_HEADER_BYTES))
      else $error("open packet with short header length");
`endif

endmodule

/* hdl/ipv4rx_rsp_reg.sv */
module ipv4rx_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ipv4rx_pkg::result_type load_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ipv4rx_pkg::result_type rsp_data,
   output logic                   free
);
   import ipv4rx_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
      if (free && load) begin
         data_ff <= load_data;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(data_ff))
      else $error("pending result word lost");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      free && load |=> valid_ff)
      else $error("loaded result word not shown");

   a_empty_after_take: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !load |=> !valid_ff)
      else $error("result word repeated");
`endif

endmodule

/* hdl/ipv4_receive_header_check.sv */
// IPv4 receive header check.
// Packet bytes enter on the req_ channel (valid/ready), one byte per word,
// with req_first marking the first byte of a packet. Results leave on the
// rsp_ channel: one header report (rsp_kind 0) after the last header byte, or
// on the first byte if IHL is below 5; then, when the header is good, one word
// per payload byte (rsp_kind 1) with rsp_last on the final one. Errors end it at the report.
// csr_ writes the local address; it is always ready and should only be
// written while no packet is in flight.
// A result passes two registers: the accepted byte sits in the input register,
// and when the result register is free its result moves into it. One byte per
// cycle is taken while the rsp_ side does not stall; the header capture and
// ones' complement add sit between the two registers.
// A stalled rsp_ side holds the result register; the input register then
// fills and req_ready drops, so nothing is lost.
// Reset (synchronous, active high) clears the address to zero and leaves the
// block ignoring bytes until the next first byte.
module ipv4_receive_header_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dest_addr,
   output logic [15:0] rsp_packet_id,
   output logic        rsp_dont_fragment,
   output logic        rsp_more_fragments,
   output logic [12:0] rsp_frag_offset,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_local_ip_addr
);
   import ipv4rx_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic [31:0] local_ip_addr_ff;

   logic        step;
   logic        out_free;
   result_type  core_res;
   logic        core_res_valid;
   result_type  rsp_data;

   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         local_ip_addr_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (csr_valid) begin
            local_ip_addr_ff <= csr_local_ip_addr;
         end
      end
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first;
      end
   end

   ipv4rx_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (in_byte_ff),
      .first         (in_first_ff),
      .local_ip_addr (local_ip_addr_ff),
      .res           (core_res),
      .res_valid     (core_res_valid)
   );

   ipv4rx_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step && core_res_valid),
      .load_data (core_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_status         = rsp_data.status;
   assign rsp_src_addr       = rsp_data.src_addr;
   assign rsp_dest_addr      = rsp_data.dest_addr;
   assign rsp_packet_id      = rsp_data.packet_id;
   assign rsp_dont_fragment  = rsp_data.dont_fragment;
   assign rsp_more_fragments = rsp_data.more_fragments;
   assign rsp_frag_offset    = rsp_data.frag_offset;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_last           = rsp_data.last;

endmodule
